// ===== rtl/dwo_pkg.sv =====
package dwo_pkg;

    localparam int CNT_IN_W   = 16;
    localparam int POS_W      = 32;
    localparam int DIST_W     = 31;
    localparam int CIRC_W     = 10;
    localparam int CPR_W      = 16;
    localparam int C10_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int LOOP_W     = $clog2(DIST_W + 1);
    localparam int STEP_W     = 4;
    localparam int UC_DEPTH   = 1 << STEP_W;

    localparam logic [CIRC_W-1:0] CIRC_RESET = CIRC_W'(204);
    localparam logic [CPR_W-1:0]  CPR_RESET  = CPR_W'(1040);

    localparam logic [CFG_IDX_W-1:0] REG_CIRC = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CPR  = CFG_IDX_W'(1);

    typedef struct packed {
        logic                req_type;
        logic [CNT_IN_W-1:0] left_count;
        logic [CNT_IN_W-1:0] right_count;
    } t_in_word;

    typedef struct packed {
        logic signed [POS_W-1:0] left_position;
        logic signed [POS_W-1:0] right_position;
        logic [DIST_W-1:0]       distance_tenth_mm;
    } t_out_word;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_STEP,
        OP_CLEAR,
        OP_SUM,
        OP_MUL,
        OP_ADD,
        OP_DIVINIT,
        OP_DIVSTEP,
        OP_OUTPUT
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_CLEAR,
        C_SAT,
        C_LOOP,
        C_OUT_BUSY
    } t_cond;

    typedef logic [STEP_W-1:0] t_step;

    localparam t_step S_WAIT     = STEP_W'(0);
    localparam t_step S_DISPATCH = STEP_W'(1);
    localparam t_step S_STEP     = STEP_W'(2);
    localparam t_step S_CLEAR    = STEP_W'(3);
    localparam t_step S_SUM      = STEP_W'(4);
    localparam t_step S_MUL      = STEP_W'(5);
    localparam t_step S_ADD      = STEP_W'(6);
    localparam t_step S_DIVINIT  = STEP_W'(7);
    localparam t_step S_DIVSTEP  = STEP_W'(8);
    localparam t_step S_OUTPUT   = STEP_W'(9);
    localparam t_step S_RETURN   = STEP_W'(10);

    // One control word per step: datapath operation, jump condition, loop
    // counter load and jump target. A false condition falls through.
    typedef struct packed {
        t_op   op;
        t_cond cond;
        logic  ld_loop;
        t_step target;
    } t_uword;

    typedef struct packed {
        logic in_valid;
        logic out_busy;
        logic clear;
        logic sat;
    } t_seq_status;

    typedef struct packed {
        logic clear;
        logic sat;
    } t_dp_status;

    localparam t_uword UCODE [0:UC_DEPTH-1] = '{
        '{OP_ACCEPT,  C_NO_INPUT, 1'b0, S_WAIT},
        '{OP_NONE,    C_CLEAR,    1'b0, S_CLEAR},
        '{OP_STEP,    C_ALWAYS,   1'b0, S_SUM},
        '{OP_CLEAR,   C_NEVER,    1'b0, S_SUM},
        '{OP_SUM,     C_NEVER,    1'b0, S_MUL},
        '{OP_MUL,     C_NEVER,    1'b0, S_ADD},
        '{OP_ADD,     C_NEVER,    1'b0, S_DIVINIT},
        '{OP_DIVINIT, C_SAT,      1'b1, S_OUTPUT},
        '{OP_DIVSTEP, C_LOOP,     1'b0, S_DIVSTEP},
        '{OP_OUTPUT,  C_OUT_BUSY, 1'b0, S_OUTPUT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT},
        '{OP_NONE,    C_ALWAYS,   1'b0, S_WAIT}
    };

endpackage

// ===== rtl/dual_wheel_odometry_accumulator_core.sv =====
// Dual-wheel odometry accumulator. Each input word either samples the two
// wrapping encoder counters or clears all positions and travel totals; every
// word returns one result word with both signed positions and the rounded
// mean travelled distance in tenths of a millimetre, saturating at 2^31-1.
// Words are handled one at a time by a small microprogram: a normal word
// passes through the bit-serial restoring divider, and the input is ready
// again only after the result is loaded into the output register. A
// saturating distance skips the divider. A result still waiting on the
// output holds the sequencer at its output step. Configuration writes are
// always accepted.
module dual_wheel_odometry_accumulator_core
    import dwo_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int TOTAL_BITS   = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CIRC_W-1:0] r_circ;
    logic [CPR_W-1:0]  r_cpr;
    logic              r_out_valid;
    t_out_word         r_out_word;

    t_uword      uword;
    t_seq_status seq_stat;
    t_dp_status  dp_stat;
    t_out_word   result;
    logic        in_fire;
    logic        out_busy;
    logic        out_load;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (uword.op == OP_ACCEPT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_busy    = r_out_valid && !i_out_ready;
    assign out_load    = (uword.op == OP_OUTPUT) && !out_busy;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign seq_stat.in_valid = i_in_valid;
    assign seq_stat.out_busy = out_busy;
    assign seq_stat.clear    = dp_stat.clear;
    assign seq_stat.sat      = dp_stat.sat;

    dwo_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (seq_stat),
        .o_uword (uword)
    );

    dwo_dp #(
        .COUNTER_BITS (COUNTER_BITS),
        .TOTAL_BITS   (TOTAL_BITS)
    ) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_op      (uword.op),
        .i_in_fire (in_fire),
        .i_in_word (i_in_word),
        .i_circ    (r_circ),
        .i_cpr     (r_cpr),
        .o_stat    (dp_stat),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ <= CIRC_RESET;
            r_cpr  <= CPR_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_CIRC: r_circ <= i_cfg_data[CIRC_W-1:0];
                REG_CPR:  r_cpr  <= i_cfg_data[CPR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word <= result;
        end
    end

    // Once a word is taken the sequencer must leave its accept step.
    a_accept_leaves_wait : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !o_in_ready
    ) else $error("input still ready right after a word was accepted");

    // A new result only appears from the output step.
    a_result_from_output_step : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(uword.op == OP_OUTPUT)
    ) else $error("result word raised outside the output step");

    // A blocked output holds the sequencer at its output step.
    a_output_step_holds : assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ((uword.op == OP_OUTPUT) && out_busy) |=> (uword.op == OP_OUTPUT)
    ) else $error("sequencer left the output step with the result not delivered");

endmodule

// ===== rtl/dwo_seq.sv =====
module dwo_seq
    import dwo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_seq_status i_stat,
    output t_uword      o_uword
);

    t_step             r_step;
    t_step             n_step;
    logic [LOOP_W-1:0] r_loop;
    t_uword            uword;
    logic              jump;

    assign uword   = UCODE[r_step];
    assign o_uword = uword;

    always_comb begin
        case (uword.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !i_stat.in_valid;
            C_CLEAR:    jump = i_stat.clear;
            C_SAT:      jump = i_stat.sat;
            C_LOOP:     jump = (r_loop != LOOP_W'(1));
            C_OUT_BUSY: jump = i_stat.out_busy;
            default:    jump = 1'b1;
        endcase
        n_step = jump ? uword.target : r_step + STEP_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_WAIT;
            r_loop <= '0;
        end else begin
            r_step <= n_step;
            if (uword.ld_loop) begin
                r_loop <= LOOP_W'(DIST_W);
            end else if (uword.cond == C_LOOP) begin
                r_loop <= r_loop - LOOP_W'(1);
            end
        end
    end

endmodule

// ===== rtl/dwo_dp.sv =====
module dwo_dp
    import dwo_pkg::*;
#(
    parameter int COUNTER_BITS = 16,
    parameter int TOTAL_BITS   = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_op               i_op,
    input  logic              i_in_fire,
    input  t_in_word          i_in_word,
    input  logic [CIRC_W-1:0] i_circ,
    input  logic [CPR_W-1:0]  i_cpr,
    output t_dp_status        o_stat,
    output t_out_word         o_result
);

    localparam int CB      = COUNTER_BITS;
    localparam int TB      = TOTAL_BITS;
    localparam int PROD_W  = TB + C10_W;
    // The divider needs at least a divisor's width above the quotient bits.
    localparam int NUM_MIN = DIST_W + CPR_W;
    localparam int NUM_W   = (TB + C10_W + 1 > NUM_MIN) ? TB + C10_W + 1 : NUM_MIN;
    localparam int HI_W    = NUM_W - DIST_W;

    // Architectural state
    logic [CB-1:0] r_lprev, r_rprev;
    logic [TB-1:0] r_lpos, r_rpos;
    logic [TB-1:0] r_ltrav, r_rtrav;

    // Working registers
    t_in_word          r_in;
    logic [TB-1:0]     r_avg;
    logic [C10_W-1:0]  r_c10;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_num;
    logic [CPR_W-1:0]  r_rem;
    logic [DIST_W-1:0] r_quo;

    logic [CB-1:0]        lt_now, rt_now;
    logic [CB-1:0]        lt_diff, rt_diff;
    logic signed [CB-1:0] lt_sdiff, rt_sdiff;
    logic [CB-1:0]        lt_mag, rt_mag;
    logic [TB:0]          travel_sum;
    logic [CPR_W-1:0]     div;
    logic [HI_W-1:0]      num_hi;
    logic                 sat;
    logic [CPR_W:0]       trial;
    logic [CPR_W:0]       trial_sub;
    logic                 trial_ge;

    assign lt_now   = CB'(r_in.left_count);
    assign rt_now   = CB'(r_in.right_count);
    assign lt_diff  = lt_now - r_lprev;
    assign rt_diff  = rt_now - r_rprev;
    assign lt_sdiff = signed'(lt_diff);
    assign rt_sdiff = signed'(rt_diff);
    // The most negative step keeps its full magnitude in CB unsigned bits.
    assign lt_mag   = lt_diff[CB-1] ? (~lt_diff + CB'(1)) : lt_diff;
    assign rt_mag   = rt_diff[CB-1] ? (~rt_diff + CB'(1)) : rt_diff;

    assign travel_sum = {1'b0, r_ltrav} + {1'b0, r_rtrav};
    assign div        = (i_cpr == '0) ? CPR_W'(1) : i_cpr;

    // The quotient fits in the distance field exactly when the part of the
    // numerator above the quotient bits is below the divisor.
    assign num_hi = HI_W'(r_num >> DIST_W);
    assign sat    = (num_hi >= HI_W'(div));

    assign trial     = {r_rem, r_quo[DIST_W-1]};
    assign trial_ge  = (trial >= {1'b0, div});
    assign trial_sub = trial - {1'b0, div};

    assign o_stat.clear = r_in.req_type;
    assign o_stat.sat   = sat;

    assign o_result.left_position     = signed'(POS_W'(r_lpos));
    assign o_result.right_position    = signed'(POS_W'(r_rpos));
    assign o_result.distance_tenth_mm = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lprev <= '0;
            r_rprev <= '0;
            r_lpos  <= '0;
            r_rpos  <= '0;
            r_ltrav <= '0;
            r_rtrav <= '0;
        end else begin
            case (i_op)
                OP_STEP: begin
                    r_lprev <= lt_now;
                    r_rprev <= rt_now;
                    r_lpos  <= r_lpos + TB'(lt_sdiff);
                    r_rpos  <= r_rpos + TB'(rt_sdiff);
                    r_ltrav <= r_ltrav + TB'(lt_mag);
                    r_rtrav <= r_rtrav + TB'(rt_mag);
                end
                OP_CLEAR: begin
                    r_lprev <= '0;
                    r_rprev <= '0;
                    r_lpos  <= '0;
                    r_rpos  <= '0;
                    r_ltrav <= '0;
                    r_rtrav <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_ACCEPT: begin
                if (i_in_fire) begin
                    r_in <= i_in_word;
                end
            end
            OP_SUM: begin
                r_avg <= travel_sum[TB:1];
                r_c10 <= C10_W'({i_circ, 3'b000}) + C10_W'({i_circ, 1'b0});
            end
            OP_MUL: begin
                r_prod <= PROD_W'(r_avg) * PROD_W'(r_c10);
            end
            OP_ADD: begin
                r_num <= NUM_W'(r_prod) + NUM_W'(div[CPR_W-1:1]);
            end
            OP_DIVINIT: begin
                if (sat) begin
                    r_quo <= '1;
                end else begin
                    r_rem <= num_hi[CPR_W-1:0];
                    r_quo <= r_num[DIST_W-1:0];
                end
            end
            OP_DIVSTEP: begin
                r_rem <= trial_ge ? trial_sub[CPR_W-1:0] : trial[CPR_W-1:0];
                r_quo <= {r_quo[DIST_W-2:0], trial_ge};
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== tb/dual_wheel_odometry_accumulator_core_test.sv =====
`timescale 1ns / 100ps

module dual_wheel_odometry_accumulator_core_test;
    import dwo_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int END_SETTLE     = 60;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_WORDS    = 175;

    localparam logic [63:0] DIST_SCALE = 64'd10;
    localparam logic [63:0] DIST_CEIL  = (64'd1 << DIST_W) - 64'd1;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

    localparam logic [CNT_IN_W-1:0] STEP_CORNERS [6] = '{
        16'h7FFF, 16'h8000, 16'hFFFF, 16'h0001, 16'h8001, 16'h0000
    };

    logic clk;
    logic rst_n = 1'b0;

    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_word              in_word   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_out_word             out_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Predicted register and accumulator contents.
    logic [CIRC_W-1:0]   odo_circ;
    logic [CPR_W-1:0]    odo_cpr;
    logic [CNT_IN_W-1:0] left_last;
    logic [CNT_IN_W-1:0] right_last;
    logic [POS_W-1:0]    left_pos;
    logic [POS_W-1:0]    right_pos;
    logic [POS_W-1:0]    left_travel;
    logic [POS_W-1:0]    right_travel;

    t_out_word pending_odometry [$];

    int fail_count  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_stall    = 0;
    int rx_tick     = 0;
    logic rx_steady = 1'b0;

    dual_wheel_odometry_accumulator_core i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    task automatic report_mismatch(input string field, input logic [63:0] want,
                                   input logic [63:0] got);
        $display("%0t ns: mismatch on %s, expected %h, got %h", $time, field, want, got);
        fail_count++;
    endtask

    function automatic t_out_word predict_odometry(input t_in_word w);
        logic [CNT_IN_W-1:0] l_step;
        logic [CNT_IN_W-1:0] r_step;
        logic [CNT_IN_W-1:0] l_mag;
        logic [CNT_IN_W-1:0] r_mag;
        logic [POS_W:0]      both;
        logic [63:0]         divisor;
        logic [63:0]         scaled;
        logic [63:0]         quotient;
        t_out_word           r;
        if (w.req_type) begin
            left_last    = '0;
            right_last   = '0;
            left_pos     = '0;
            right_pos    = '0;
            left_travel  = '0;
            right_travel = '0;
        end else begin
            l_step = w.left_count - left_last;
            r_step = w.right_count - right_last;
            // The magnitude of the most negative step still fits the counter width.
            l_mag = l_step[CNT_IN_W-1] ? -l_step : l_step;
            r_mag = r_step[CNT_IN_W-1] ? -r_step : r_step;
            left_pos     = left_pos + {{(POS_W-CNT_IN_W){l_step[CNT_IN_W-1]}}, l_step};
            right_pos    = right_pos + {{(POS_W-CNT_IN_W){r_step[CNT_IN_W-1]}}, r_step};
            left_travel  = left_travel + POS_W'(l_mag);
            right_travel = right_travel + POS_W'(r_mag);
            left_last    = w.left_count;
            right_last   = w.right_count;
        end
        both     = {1'b0, left_travel} + {1'b0, right_travel};
        divisor  = (odo_cpr == '0) ? 64'd1 : 64'(odo_cpr);
        scaled   = 64'(both >> 1) * 64'(odo_circ) * DIST_SCALE + (divisor >> 1);
        quotient = scaled / divisor;
        r.left_position     = left_pos;
        r.right_position    = right_pos;
        r.distance_tenth_mm = (quotient > DIST_CEIL) ? DIST_W'(DIST_CEIL)
                                                     : quotient[DIST_W-1:0];
        return r;
    endfunction

    function automatic t_in_word random_word();
        int unsigned kind;
        int          d;
        t_in_word    w;
        kind       = $urandom_range(0, 99);
        w.req_type = 1'b0;
        if (kind < 3) begin
            w.req_type    = 1'b1;
            w.left_count  = CNT_IN_W'($urandom);
            w.right_count = CNT_IN_W'($urandom);
        end else if (kind < 13) begin
            w.left_count  = CNT_IN_W'($urandom);
            w.right_count = CNT_IN_W'($urandom);
        end else if (kind < 23) begin
            w.left_count  = left_last + STEP_CORNERS[$urandom_range(0, 5)];
            w.right_count = right_last + STEP_CORNERS[$urandom_range(0, 5)];
        end else begin
            // Ordinary driving: both wheels move by similar small amounts.
            d             = int'($urandom_range(0, 600)) - 300;
            w.left_count  = left_last + CNT_IN_W'(d + int'($urandom_range(0, 40)) - 20);
            w.right_count = right_last + CNT_IN_W'(d + int'($urandom_range(0, 40)) - 20);
        end
        return w;
    endfunction

    task automatic send_word(input t_in_word w);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 100)
                                                     : $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 60);
            if (gap != 0) begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
        pending_odometry.push_back(predict_odometry(w));
    endtask

    task automatic send_counts(input logic clear, input logic [CNT_IN_W-1:0] l,
                               input logic [CNT_IN_W-1:0] r);
        t_in_word w;
        w.req_type    = clear;
        w.left_count  = l;
        w.right_count = r;
        send_word(w);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_odometry.size() != 0) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CIRC: odo_circ = data[CIRC_W-1:0];
            REG_CPR:  odo_cpr  = data[CPR_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_scaling(input logic [CIRC_W-1:0] circ, input logic [CPR_W-1:0] cpr);
        wait_drained();
        // Bits above the circumference field are junk that must be ignored.
        write_register(REG_CIRC, {(CFG_DATA_W-CIRC_W)'($urandom), circ});
        write_register(REG_CPR, cpr);
    endtask

    task automatic test_power_on_defaults();
        send_counts(1'b0, 16'h0000, 16'h0000);
        send_counts(1'b0, 16'd1040, 16'd1040);
    endtask

    task automatic test_step_extremes();
        foreach (STEP_CORNERS[i])
            send_counts(1'b0, left_last + STEP_CORNERS[i], right_last - STEP_CORNERS[i]);
        send_counts(1'b0, 16'hFFFF, 16'hFFFF);
        send_counts(1'b0, 16'h0000, 16'h0000);
    endtask

    task automatic test_clear_request();
        send_counts(1'b1, 16'hFFFF, 16'hFFFF);
        send_counts(1'b0, 16'h1234, 16'hEDCB);
        send_counts(1'b1, 16'h0000, 16'h0000);
    endtask

    task automatic test_register_map();
        wait_drained();
        write_register(REG_SPARE_LO, CFG_DATA_W'($urandom));
        write_register(REG_SPARE_HI, CFG_DATA_W'($urandom));
        write_register(REG_CIRC, 16'hFC00 | 16'd204);
        send_counts(1'b0, 16'h0100, 16'h00F0);
    endtask

    task automatic test_distance_corners();
        set_scaling('0, CPR_RESET);
        send_counts(1'b0, left_last + 16'h0400, right_last + 16'h0400);
        set_scaling(CIRC_RESET, '0);
        send_counts(1'b0, left_last + 16'h0003, right_last - 16'h0002);
        // Rounding: odd sums and a divisor of three.
        set_scaling(CIRC_W'(1), CPR_W'(3));
        send_counts(1'b1, 16'h0000, 16'h0000);
        send_counts(1'b0, 16'h0001, 16'h0002);
        // Largest scale factor drives the distance into saturation.
        set_scaling('1, CPR_W'(1));
        repeat (8) send_counts(1'b0, left_last + 16'h7FFF, right_last - 16'h8000);
    endtask

    task automatic test_random_phases();
        logic [CIRC_W-1:0] circ;
        logic [CPR_W-1:0]  cpr;
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                0: begin circ = CIRC_RESET;  cpr = CPR_RESET;  end
                1: begin circ = '1;          cpr = CPR_W'(1);  end
                2: begin circ = CIRC_W'(1);  cpr = '1;         end
                3: begin circ = '0;          cpr = CPR_W'($urandom); end
                4: begin circ = CIRC_W'($urandom); cpr = '0;   end
                default: begin circ = CIRC_W'($urandom); cpr = CPR_W'($urandom); end
            endcase
            set_scaling(circ, cpr);
            repeat (PHASE_WORDS) send_word(random_word());
        end
    endtask

    // Receiver stalls in random stretches, with spells of steady acceptance.
    always @(negedge clk) begin
        if (rx_tick == 0) begin
            rx_steady <= ($urandom_range(0, 2) == 0);
            rx_tick   <= $urandom_range(200, 800);
        end else begin
            rx_tick <= rx_tick - 1;
        end
        if (rx_stall != 0) begin
            rx_stall  <= rx_stall - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
            if (!rx_steady && $urandom_range(0, 3) == 0)
                rx_stall <= $urandom_range(1, 20);
        end
    end

    always @(posedge clk) begin : result_check
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_odometry.size() == 0) begin
                report_mismatch("unexpected result word", '0, 64'(out_word));
            end else begin
                want = pending_odometry.pop_front();
                if (out_word.left_position !== want.left_position)
                    report_mismatch("left_position", 64'(want.left_position),
                                    64'(out_word.left_position));
                if (out_word.right_position !== want.right_position)
                    report_mismatch("right_position", 64'(want.right_position),
                                    64'(out_word.right_position));
                if (out_word.distance_tenth_mm !== want.distance_tenth_mm)
                    report_mismatch("distance_tenth_mm", 64'(want.distance_tenth_mm),
                                    64'(out_word.distance_tenth_mm));
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("dual_wheel_odometry_accumulator_core_test failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        odo_circ     = CIRC_RESET;
        odo_cpr      = CPR_RESET;
        left_last    = '0;
        right_last   = '0;
        left_pos     = '0;
        right_pos    = '0;
        left_travel  = '0;
        right_travel = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_power_on_defaults();
        test_step_extremes();
        test_clear_request();
        test_register_map();
        test_distance_corners();
        test_random_phases();

        wait_drained();
        repeat (END_SETTLE) @(posedge clk);
        if (fail_count == 0)
            $display("dual_wheel_odometry_accumulator_core_test passed");
        else
            $display("dual_wheel_odometry_accumulator_core_test failed");
        $finish;
    end

endmodule
